// ===== hdl/letterbox_nearest_scaler_unit_assert.svh =====
// Assertion macros for the letterbox scaler.
// Both expect signals named clock and reset in the calling scope.
`ifndef LETTERBOX_NEAREST_SCALER_UNIT_ASSERT_SVH
`define LETTERBOX_NEAREST_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LBS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lbs: same-cycle check failed");

// Next-cycle implication.
`define LBS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lbs: next-cycle check failed");

`endif

// ===== hdl/lbs_pkg.sv =====
package lbs_pkg;

   localparam int PixW        = 12;
   localparam int DimW        = 13;
   localparam int IdxW        = 24;
   localparam int ProdW       = PixW + DimW;
   localparam int QuoW        = DimW;
   localparam int QuoIdxW     = $clog2(QuoW);
   localparam int BitsPerStep = 2;
   localparam int DivStages   = (QuoW + BitsPerStep - 1) / BitsPerStep;
   // window check, product, divider steps, index multiply, output register
   localparam int NumStages   = DivStages + 4;
   localparam int StgMul      = 1;
   localparam int StgDiv0     = 2;
   localparam int StgQmul     = StgDiv0 + DivStages;
   localparam int StgOut      = NumStages - 1;
   localparam int MaxDim      = 4096;
   localparam int AddrW       = 5;
   localparam int DataW       = 32;

   localparam logic [DimW-1:0] PanelWidthRst  = 13'd640;
   localparam logic [DimW-1:0] PanelHeightRst = 13'd480;

   typedef enum logic [2:0] {
      CsrSrcWidth,
      CsrSrcHeight,
      CsrWinLeft,
      CsrWinTop,
      CsrWinWidth,
      CsrWinHeight,
      CsrPanelWidth,
      CsrPanelHeight
   } csr_index_type;

endpackage

// ===== hdl/lbs_req_if.sv =====
interface lbs_req_if;
   logic                     valid;
   logic                     ready;
   logic [lbs_pkg::PixW-1:0] pix_x;
   logic [lbs_pkg::PixW-1:0] pix_y;

   modport source (output valid, output pix_x, output pix_y, input ready);
   modport sink (input valid, input pix_x, input pix_y, output ready);
endinterface

// ===== hdl/lbs_rsp_if.sv =====
interface lbs_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     inside_res;
   logic [lbs_pkg::PixW-1:0] src_col;
   logic [lbs_pkg::PixW-1:0] src_row;
   logic [lbs_pkg::IdxW-1:0] src_index;

   modport source (output valid, output inside_res, output src_col, output src_row,
                   output src_index, input ready);
   modport sink (input valid, input inside_res, input src_col, input src_row,
                 input src_index, output ready);
endinterface

// ===== hdl/lbs_div_lane.sv =====
module lbs_div_lane (
   input  logic                                clock,
   input  logic [lbs_pkg::DivStages-1:0]       adv,
   input  logic [lbs_pkg::ProdW-1:0]           dividend,
   input  logic [lbs_pkg::QuoW-1:0]            divisor,
   output logic [lbs_pkg::QuoW-1:0]            quotient
);

   logic [lbs_pkg::ProdW-1:0] rem_ff [lbs_pkg::DivStages];
   logic [lbs_pkg::ProdW-1:0] rem_in [lbs_pkg::DivStages];
   logic [lbs_pkg::QuoW-1:0]  quo_ff [lbs_pkg::DivStages];
   logic [lbs_pkg::QuoW-1:0]  quo_in [lbs_pkg::DivStages];

   // Restoring division, BitsPerStep quotient bits per stage, MSB first.
   // The quotient is known to fit QuoW bits whenever the result is used.
   always_comb begin
      logic [lbs_pkg::ProdW-1:0] r;
      logic [lbs_pkg::ProdW-1:0] dsh;
      logic [lbs_pkg::QuoW-1:0]  q;
      int                        k;
      for (int s = 0; s < lbs_pkg::DivStages; s++) begin
         if (s == 0) begin
            r = dividend;
            q = '0;
         end else begin
            r = rem_ff[s-1];
            q = quo_ff[s-1];
         end
         for (int t = 0; t < lbs_pkg::BitsPerStep; t++) begin
            k = lbs_pkg::QuoW - 1 - s * lbs_pkg::BitsPerStep - t;
            if (k >= 0) begin
               dsh = lbs_pkg::ProdW'(divisor) << k;
               if (r >= dsh) begin
                  r = r - dsh;
                  q[lbs_pkg::QuoIdxW'(k)] = 1'b1;
               end
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < lbs_pkg::DivStages; s++) begin
         if (adv[s]) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quotient = quo_ff[lbs_pkg::DivStages-1];

endmodule

// ===== hdl/letterbox_nearest_scaler_unit.sv =====
// Throughput: one pixel per cycle unless rsp_ch stalls; the pipeline fills and
// drains freely, and each of the two divider lanes resolves two quotient bits
// per stage. Backpressure stalls only as far back as the first empty stage.
// Reset (synchronous): pipeline emptied, registers to reset values
// (panel 640 x 480, all others zero).
`include "letterbox_nearest_scaler_unit_assert.svh"

module letterbox_nearest_scaler_unit #(
   parameter int MaxDim = lbs_pkg::MaxDim
) (
   input  logic                          clock,
   input  logic                          reset,
   lbs_req_if.sink                       req_ch,
   lbs_rsp_if.source                     rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lbs_pkg::AddrW-1:0]     paddr,
   input  logic [lbs_pkg::DataW-1:0]     pwdata,
   output logic [lbs_pkg::DataW-1:0]     prdata,
   output logic                          pready
);

   localparam int Last = lbs_pkg::NumStages - 1;

   // ---------------- configuration registers ----------------
   logic [lbs_pkg::DimW-1:0] src_width_ff, src_width_in;
   logic [lbs_pkg::DimW-1:0] src_height_ff, src_height_in;
   logic [lbs_pkg::PixW-1:0] win_left_ff, win_left_in;
   logic [lbs_pkg::PixW-1:0] win_top_ff, win_top_in;
   logic [lbs_pkg::DimW-1:0] win_width_ff, win_width_in;
   logic [lbs_pkg::DimW-1:0] win_height_ff, win_height_in;
   logic [lbs_pkg::DimW-1:0] panel_width_ff, panel_width_in;
   logic [lbs_pkg::DimW-1:0] panel_height_ff, panel_height_in;

   logic                   csr_wr;
   lbs_pkg::csr_index_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = lbs_pkg::csr_index_type'(paddr[lbs_pkg::AddrW-1:2]);

   always_comb begin
      src_width_in    = src_width_ff;
      src_height_in   = src_height_ff;
      win_left_in     = win_left_ff;
      win_top_in      = win_top_ff;
      win_width_in    = win_width_ff;
      win_height_in   = win_height_ff;
      panel_width_in  = panel_width_ff;
      panel_height_in = panel_height_ff;
      if (csr_wr) begin
         case (csr_idx)
            lbs_pkg::CsrSrcWidth:    src_width_in    = pwdata[lbs_pkg::DimW-1:0];
            lbs_pkg::CsrSrcHeight:   src_height_in   = pwdata[lbs_pkg::DimW-1:0];
            lbs_pkg::CsrWinLeft:     win_left_in     = pwdata[lbs_pkg::PixW-1:0];
            lbs_pkg::CsrWinTop:      win_top_in      = pwdata[lbs_pkg::PixW-1:0];
            lbs_pkg::CsrWinWidth:    win_width_in    = pwdata[lbs_pkg::DimW-1:0];
            lbs_pkg::CsrWinHeight:   win_height_in   = pwdata[lbs_pkg::DimW-1:0];
            lbs_pkg::CsrPanelWidth:  panel_width_in  = pwdata[lbs_pkg::DimW-1:0];
            lbs_pkg::CsrPanelHeight: panel_height_in = pwdata[lbs_pkg::DimW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff    <= '0;
         src_height_ff   <= '0;
         win_left_ff     <= '0;
         win_top_ff      <= '0;
         win_width_ff    <= '0;
         win_height_ff   <= '0;
         panel_width_ff  <= lbs_pkg::PanelWidthRst;
         panel_height_ff <= lbs_pkg::PanelHeightRst;
      end else begin
         src_width_ff    <= src_width_in;
         src_height_ff   <= src_height_in;
         win_left_ff     <= win_left_in;
         win_top_ff      <= win_top_in;
         win_width_ff    <= win_width_in;
         win_height_ff   <= win_height_in;
         panel_width_ff  <= panel_width_in;
         panel_height_ff <= panel_height_in;
      end
   end

   always_comb begin
      case (csr_idx)
         lbs_pkg::CsrSrcWidth:    prdata = lbs_pkg::DataW'(src_width_ff);
         lbs_pkg::CsrSrcHeight:   prdata = lbs_pkg::DataW'(src_height_ff);
         lbs_pkg::CsrWinLeft:     prdata = lbs_pkg::DataW'(win_left_ff);
         lbs_pkg::CsrWinTop:      prdata = lbs_pkg::DataW'(win_top_ff);
         lbs_pkg::CsrWinWidth:    prdata = lbs_pkg::DataW'(win_width_ff);
         lbs_pkg::CsrWinHeight:   prdata = lbs_pkg::DataW'(win_height_ff);
         lbs_pkg::CsrPanelWidth:  prdata = lbs_pkg::DataW'(panel_width_ff);
         lbs_pkg::CsrPanelHeight: prdata = lbs_pkg::DataW'(panel_height_ff);
         default:                 prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic [lbs_pkg::NumStages-1:0] v_ff;
   logic [lbs_pkg::NumStages-1:0] v_in;
   logic [lbs_pkg::NumStages-1:0] en;
   logic                          ins_ff [lbs_pkg::NumStages];
   logic                          ins_in [lbs_pkg::NumStages];

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      en[Last] = !v_ff[Last] || rsp_ch.ready;
      for (int k = Last - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = req_ch.valid;
      for (int k = 1; k < lbs_pkg::NumStages; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < lbs_pkg::NumStages; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign req_ch.ready = en[0];

   // ---------------- stage 0: window test ----------------
   logic                     cfg_ok;
   logic                     win_hit;
   logic [lbs_pkg::PixW-1:0] i_ff, i_in;
   logic [lbs_pkg::PixW-1:0] j_ff, j_in;

   assign cfg_ok = src_width_ff != '0 && src_height_ff != '0 &&
                   win_width_ff != '0 && win_height_ff != '0 &&
                   lbs_pkg::DimW'(win_left_ff) < panel_width_ff &&
                   lbs_pkg::DimW'(win_top_ff) < panel_height_ff;

   assign i_in = req_ch.pix_x - win_left_ff;
   assign j_in = req_ch.pix_y - win_top_ff;

   // Clipping to the panel reduces to comparing the pixel against the panel edge.
   assign win_hit = cfg_ok &&
                    req_ch.pix_x >= win_left_ff && req_ch.pix_y >= win_top_ff &&
                    lbs_pkg::DimW'(req_ch.pix_x) < panel_width_ff &&
                    lbs_pkg::DimW'(req_ch.pix_y) < panel_height_ff &&
                    lbs_pkg::DimW'(i_in) < win_width_ff &&
                    lbs_pkg::DimW'(j_in) < win_height_ff &&
                    int'(i_in) < MaxDim;

   // ---------------- stage 1: scale products ----------------
   logic [lbs_pkg::ProdW-1:0] pcol_ff, pcol_in;
   logic [lbs_pkg::ProdW-1:0] prow_ff, prow_in;

   assign pcol_in = lbs_pkg::ProdW'(i_ff) * lbs_pkg::ProdW'(src_width_ff);
   assign prow_in = lbs_pkg::ProdW'(j_ff) * lbs_pkg::ProdW'(src_height_ff);

   // ---------------- divider stages ----------------
   logic [lbs_pkg::QuoW-1:0] q_col;
   logic [lbs_pkg::QuoW-1:0] q_row;

   lbs_div_lane u_div_col (
      .clock    (clock),
      .adv      (en[lbs_pkg::StgQmul-1:lbs_pkg::StgDiv0]),
      .dividend (pcol_ff),
      .divisor  (win_width_ff),
      .quotient (q_col)
   );

   lbs_div_lane u_div_row (
      .clock    (clock),
      .adv      (en[lbs_pkg::StgQmul-1:lbs_pkg::StgDiv0]),
      .dividend (prow_ff),
      .divisor  (win_height_ff),
      .quotient (q_row)
   );

   // ---------------- index multiply ----------------
   logic [2*lbs_pkg::DimW-1:0] qmul;
   logic [lbs_pkg::IdxW-1:0]   mult_ff, mult_in;
   logic [lbs_pkg::QuoW-1:0]   col_q_ff;
   logic [lbs_pkg::QuoW-1:0]   row_q_ff;

   assign qmul    = (2 * lbs_pkg::DimW)'(q_row) * (2 * lbs_pkg::DimW)'(src_width_ff);
   assign mult_in = qmul[lbs_pkg::IdxW-1:0];

   // ---------------- output register ----------------
   logic [lbs_pkg::PixW-1:0] col_ff, col_in;
   logic [lbs_pkg::PixW-1:0] row_ff, row_in;
   logic [lbs_pkg::IdxW-1:0] index_ff, index_in;
   logic [lbs_pkg::IdxW-1:0] index_sum;

   assign index_sum = mult_ff + lbs_pkg::IdxW'(col_q_ff);

   // Black bar pixels report zero coordinates.
   assign col_in   = ins_ff[Last-1] ? col_q_ff[lbs_pkg::PixW-1:0] : '0;
   assign row_in   = ins_ff[Last-1] ? row_q_ff[lbs_pkg::PixW-1:0] : '0;
   assign index_in = ins_ff[Last-1] ? index_sum : '0;

   always_comb begin
      ins_in[0] = win_hit;
      for (int k = 1; k < lbs_pkg::NumStages; k++) begin
         ins_in[k] = ins_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < lbs_pkg::NumStages; k++) begin
         if (en[k]) begin
            ins_ff[k] <= ins_in[k];
         end
      end
      if (en[0]) begin
         i_ff <= i_in;
         j_ff <= j_in;
      end
      if (en[lbs_pkg::StgMul]) begin
         pcol_ff <= pcol_in;
         prow_ff <= prow_in;
      end
      if (en[lbs_pkg::StgQmul]) begin
         mult_ff  <= mult_in;
         col_q_ff <= q_col;
         row_q_ff <= q_row;
      end
      if (en[lbs_pkg::StgOut]) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         index_ff <= index_in;
      end
   end

   assign rsp_ch.valid      = v_ff[Last];
   assign rsp_ch.inside_res = ins_ff[Last];
   assign rsp_ch.src_col    = col_ff;
   assign rsp_ch.src_row    = row_ff;
   assign rsp_ch.src_index  = index_ff;

   // ---------------- checks ----------------
   `LBS_ASSERT_NXT(a_accept_fills, req_ch.valid && req_ch.ready, v_ff[0])
   `LBS_ASSERT_IMP(a_stall_full, !req_ch.ready, v_ff == '1)
   `LBS_ASSERT_IMP(a_col_range, rsp_ch.valid && rsp_ch.inside_res,
                   lbs_pkg::DimW'(rsp_ch.src_col) < src_width_ff)
   `LBS_ASSERT_IMP(a_black_zero, rsp_ch.valid && !rsp_ch.inside_res,
                   rsp_ch.src_index == '0 && rsp_ch.src_col == '0 && rsp_ch.src_row == '0)

endmodule

// ===== verif/letterbox_nearest_scaler_unit_tb.sv =====
`timescale 1ns / 100ps

module letterbox_nearest_scaler_unit_tb;
   import lbs_pkg::*;

   typedef enum int {FlowFull, SenderIdle, SinkStall, BothIdle} flow_mode_type;

   typedef struct packed {
      logic [PixW-1:0] x;
      logic [PixW-1:0] y;
   } panel_pixel_type;

   typedef struct packed {
      logic            in_window;
      logic [PixW-1:0] col;
      logic [PixW-1:0] row;
      logic [IdxW-1:0] src_index;
   } source_ref_type;

   typedef struct {
      logic [DimW-1:0] src_w;
      logic [DimW-1:0] src_h;
      logic [PixW-1:0] win_left;
      logic [PixW-1:0] win_top;
      logic [DimW-1:0] win_w;
      logic [DimW-1:0] win_h;
      logic [DimW-1:0] panel_w;
      logic [DimW-1:0] panel_h;
   } scaler_setup_type;

   localparam int DrainCycles = NumStages + 6;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [AddrW-1:0]  paddr;
   logic [DataW-1:0]  pwdata;
   logic [DataW-1:0]  prdata;
   logic              pready;

   lbs_req_if req_ch ();
   lbs_rsp_if rsp_ch ();

   letterbox_nearest_scaler_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   scaler_setup_type setup;
   flow_mode_type    flow_mode;
   panel_pixel_type  pixel_queue[$];
   source_ref_type   expected_refs[$];
   logic             req_taken;
   int               mismatch_count;
   int               refs_checked;
   int               inside_seen;
   int               setups_applied;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Visible window after clipping; returns 0 when every pixel is black.
   function automatic logic window_open(output longint unsigned vis_w,
                                        output longint unsigned vis_h);
      vis_w = 0;
      vis_h = 0;
      if (setup.src_w == 0 || setup.src_h == 0 || setup.win_w == 0 || setup.win_h == 0 ||
          setup.win_left >= setup.panel_w || setup.win_top >= setup.panel_h)
         return 1'b0;
      vis_w = setup.win_w;
      if (vis_w > setup.panel_w - setup.win_left) vis_w = setup.panel_w - setup.win_left;
      if (vis_w > MaxDim) vis_w = MaxDim;
      vis_h = setup.win_h;
      if (vis_h > setup.panel_h - setup.win_top) vis_h = setup.panel_h - setup.win_top;
      return 1'b1;
   endfunction

   function automatic source_ref_type map_to_source(logic [PixW-1:0] x, logic [PixW-1:0] y);
      longint unsigned vis_w, vis_h, i, j, col, row, idx;
      source_ref_type  r;
      r = '0;
      if (!window_open(vis_w, vis_h)) return r;
      if (x < setup.win_left || y < setup.win_top) return r;
      i = x - setup.win_left;
      j = y - setup.win_top;
      if (i >= vis_w || j >= vis_h) return r;
      col = i * setup.src_w / setup.win_w;
      row = j * setup.src_h / setup.win_h;
      idx = row * setup.src_w + col;
      r.in_window = 1'b1;
      r.col       = col[PixW-1:0];
      r.row       = row[PixW-1:0];
      r.src_index = idx[IdxW-1:0];
      return r;
   endfunction

   function automatic logic roll(int percent);
      return $urandom_range(99) < percent;
   endfunction

   // Request driver: present the next pixel once the previous one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.pix_x <= '0;
         req_ch.pix_y <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (pixel_queue.size() > 0 &&
             !((flow_mode == SenderIdle && roll(49)) ||
               (flow_mode == BothIdle && roll(10)))) begin
            panel_pixel_type p;
            p = pixel_queue.pop_front();
            req_ch.pix_x <= p.x;
            req_ch.pix_y <= p.y;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= !((flow_mode == SinkStall && roll(49)) ||
                           (flow_mode == BothIdle && roll(10)));
   end

   // Monitor: predict on each accepted pixel, check each returned lookup.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready)
            expected_refs.push_back(map_to_source(req_ch.pix_x, req_ch.pix_y));
         if (rsp_ch.valid && rsp_ch.ready) begin
            source_ref_type got, want;
            got = '{rsp_ch.inside_res, rsp_ch.src_col, rsp_ch.src_row, rsp_ch.src_index};
            if (expected_refs.size() == 0) begin
               $display("%0t: unexpected transaction on rsp_ch: %s %0d col %0d row %0d idx %0d",
                        $time, "inside", got.in_window, got.col, got.row, got.src_index);
               mismatch_count++;
            end else begin
               want = expected_refs.pop_front();
               refs_checked++;
               if (want.in_window) inside_seen++;
               if (got !== want) begin
                  $display("%0t: mismatch expected inside %0d col %0d row %0d idx %0d,",
                           $time, want.in_window, want.col, want.row, want.src_index);
                  $display("   actual inside %0d col %0d row %0d idx %0d",
                           got.in_window, got.col, got.row, got.src_index);
                  mismatch_count++;
               end
            end
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [DataW-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CsrSrcWidth:    setup.src_w    = value[DimW-1:0];
         CsrSrcHeight:   setup.src_h    = value[DimW-1:0];
         CsrWinLeft:     setup.win_left = value[PixW-1:0];
         CsrWinTop:      setup.win_top  = value[PixW-1:0];
         CsrWinWidth:    setup.win_w    = value[DimW-1:0];
         CsrWinHeight:   setup.win_h    = value[DimW-1:0];
         CsrPanelWidth:  setup.panel_w  = value[DimW-1:0];
         CsrPanelHeight: setup.panel_h  = value[DimW-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setup(int src_w, int src_h, int win_left, int win_top,
                              int win_w, int win_h, int panel_w, int panel_h);
      write_reg(CsrSrcWidth, src_w);
      write_reg(CsrSrcHeight, src_h);
      write_reg(CsrWinLeft, win_left);
      write_reg(CsrWinTop, win_top);
      write_reg(CsrWinWidth, win_w);
      write_reg(CsrWinHeight, win_h);
      write_reg(CsrPanelWidth, panel_w);
      write_reg(CsrPanelHeight, panel_h);
      setups_applied++;
   endtask

   // Hold until every pixel went out and every lookup came back, then let
   // the pipeline settle before touching the registers.
   task automatic drain;
      while (pixel_queue.size() > 0 || req_ch.valid || expected_refs.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic add_pixel(int x, int y);
      pixel_queue.push_back('{x[PixW-1:0], y[PixW-1:0]});
   endtask

   function automatic int pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 4) return 0;
      if (r < 10) return 1;
      if (r < 18) return MaxDim;
      if (r < 26) return $urandom_range(MaxDim + 1, 8191);
      if (r < 70) return $urandom_range(1, 1024);
      return $urandom_range(1, MaxDim);
   endfunction

   function automatic int pick_panel();
      int r;
      r = $urandom_range(99);
      if (r < 30) return 640;
      if (r < 45) return MaxDim;
      if (r < 55) return 8191;
      if (r < 60) return 0;
      return $urandom_range(1, MaxDim);
   endfunction

   function automatic int pick_origin(int panel);
      if (panel > 0 && roll(85)) return $urandom_range(0, (panel > MaxDim ? MaxDim : panel) - 1);
      return $urandom_range(0, MaxDim - 1);
   endfunction

   function automatic int pick_edge(int lo, longint unsigned span);
      case ($urandom_range(3))
         0: return lo - 1;
         1: return lo;
         2: return lo + int'(span) - 1;
         default: return lo + int'(span);
      endcase
   endfunction

   task automatic queue_random_pixels(int count);
      longint unsigned vis_w, vis_h;
      logic            open;
      int              r;
      open = window_open(vis_w, vis_h);
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (open && r < 75)
            add_pixel(setup.win_left + $urandom_range(0, int'(vis_w) - 1),
                      setup.win_top + $urandom_range(0, int'(vis_h) - 1));
         else if (open && r < 88)
            add_pixel(pick_edge(setup.win_left, vis_w), pick_edge(setup.win_top, vis_h));
         else
            add_pixel($urandom, $urandom);
      end
   endtask

   initial begin
      int pw, ph;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      flow_mode      = FlowFull;
      mismatch_count = 0;
      refs_checked   = 0;
      inside_seen    = 0;
      setups_applied = 0;
      setup = '{0, 0, 0, 0, 0, 0, PanelWidthRst, PanelHeightRst};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset setup has zero sizes: all black.
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(639, 479);
      drain();

      // Pillarbox, bars left and right; probe all four window edges.
      apply_setup(320, 240, 80, 0, 480, 480, 640, 480);
      add_pixel(80, 0);
      add_pixel(559, 479);
      add_pixel(79, 0);
      add_pixel(560, 240);
      add_pixel(320, 240);
      add_pixel(80, 480);
      add_pixel(0, 0);
      add_pixel(4095, 4095);
      add_pixel(12'haaa, 12'h555);
      add_pixel(12'h555, 12'haaa);
      drain();

      // Oversized source: col and index wrap to field widths.
      apply_setup(8191, 8191, 0, 0, 1000, 1000, 640, 480);
      add_pixel(639, 479);
      add_pixel(500, 300);
      add_pixel(640, 0);
      drain();

      // Window wider than the column limit on a huge panel.
      apply_setup(MaxDim, MaxDim, 0, 4095, 8191, 1, 8191, 8191);
      add_pixel(4095, 4095);
      add_pixel(0, 4095);
      add_pixel(4095, 4094);
      drain();

      // Origin on the panel edge: all black.
      apply_setup(640, 480, 640, 0, 640, 480, 640, 480);
      add_pixel(640, 0);
      add_pixel(700, 10);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         flow_mode = flow_mode_type'(phase % 4);
         pw = pick_panel();
         ph = pick_panel();
         apply_setup(pick_dim(), pick_dim(), pick_origin(pw), pick_origin(ph),
                     pick_dim(), pick_dim(), pw, ph);
         queue_random_pixels(90);
         drain();
      end

      $display("Checked %0d lookups (%0d inside the window) across %0d register setups,",
               refs_checked, inside_seen, setups_applied);
      $display("with free flow, sender gaps, receiver stalls and both combined.");
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out with %0d lookups outstanding.", expected_refs.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
